[design/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, constants, register codes and request types of the cubic
// B-spline point generator.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int T_W           = 17;
    localparam int STEP_W        = 6;
    localparam int MAX_STEPS_DEF = 63;

    localparam logic [T_W-1:0]    T_ONE      = T_W'(1 << FRAC_W);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);
    localparam logic [T_W-1:0]    INC_RESET  = T_W'(6554);

    localparam int T2_W = 2 * T_W - 1;
    localparam int T3_W = 3 * T_W - 2;

    localparam int HI_W  = (COORD_W > FRAC_W + 1) ? COORD_W - FRAC_W : 1;
    localparam int MA_W  = T2_W + 1;
    localparam int MB_W  = ((HI_W > T_W) ? HI_W : T_W) + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int ACC_W = P_W + FRAC_W + 1;

    localparam int W_W  = 19;
    localparam int BW_W = 52;

    localparam int DIV_W   = P_W + 1;
    localparam int DIV_N   = (DIV_W + 7) / 8;
    localparam int DIV_PAD = DIV_N * 8;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(3 << FRAC_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = T_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT  = 2'd0,
        REG_T_INCREMENT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_in_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
        logic                      segment_last;
    } t_out_req;

    typedef struct packed {
        logic acc_en;
        logic first;
        logic shift;
    } t_mac_ctl;

endpackage

[design/cubic_bspline_point_generator.sv]
// ----------------------------------------------------------------------------
// cubic_bspline_point_generator
// Takes 2D control points in signed Q16.16 and, once four points are held,
// emits step_count+1 points of the uniform cubic B-spline segment for each
// new point, at t = k * t_increment saturated at 1.0, flagging the last one.
// The first three points only fill the window and give no result. All
// multiplications run on one shared multiplier-accumulator under a small
// sequencer: per curve point it forms t^2, t^3, (1-t)^2, (1-t)^3, builds the
// four weights, then eight multiply-accumulate steps per axis, each sum
// followed by a byte-serial divide by three. A point that closes a segment
// is accepted and then stalls the input until the segment's last curve
// point has been loaded into the output register, also while a result is
// held off; other points are taken without a stall. A finished curve point
// waits in the output register while the next one is computed.
// ----------------------------------------------------------------------------
module cubic_bspline_point_generator
    import cbs_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_req              o_out_req
);

    localparam int K_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_T2     = 11'b00000000010,
        S_T3     = 11'b00000000100,
        S_U2     = 11'b00000001000,
        S_U3     = 11'b00000010000,
        S_WGT    = 11'b00000100000,
        S_MUL    = 11'b00001000000,
        S_DRAIN  = 11'b00010000000,
        S_DSTART = 11'b00100000000,
        S_DWAIT  = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [STEP_W-1:0]         r_step_count;
    logic [T_W-1:0]            r_t_inc;
    logic [1:0]                r_seen;
    logic signed [COORD_W-1:0] r_win_x [3];
    logic signed [COORD_W-1:0] r_win_y [3];
    logic signed [COORD_W-1:0] r_new_x;
    logic signed [COORD_W-1:0] r_new_y;
    logic [K_W-1:0]            r_k;
    logic [T_W-1:0]            r_t;
    logic [T2_W-1:0]           r_t2;
    logic [T3_W-1:0]           r_t3;
    logic [W_W-1:0]            r_w [4];
    logic [2:0]                r_idx;
    logic                      r_axis;
    logic signed [COORD_W-1:0] r_res_x;
    logic                      r_out_valid;
    t_out_req                  r_out_req;

    logic                      n_in_take;
    logic                      n_out_load;
    logic                      n_last;
    logic [K_W-1:0]            n_steps;
    logic [T_W:0]              n_t_sum;
    logic [T_W-1:0]            n_t_next;
    logic [T_W-1:0]            n_u;
    logic [BW_W-1:0]           n_s3;
    logic [BW_W-1:0]           n_te;
    logic [BW_W-1:0]           n_t2e;
    logic [BW_W-1:0]           n_t3e;
    logic [BW_W-1:0]           n_b [4];
    logic [BW_W-1:0]           n_rb [4];
    logic signed [COORD_W-1:0] n_coord;
    logic signed [COORD_W-1:0] n_coord_shr;
    logic signed [HI_W-1:0]    n_hi;
    logic [FRAC_W-1:0]         n_lo;
    logic signed [MA_W-1:0]    n_a;
    logic signed [MB_W-1:0]    n_bop;
    t_mac_ctl                  n_ctl;
    logic                      n_div_start;
    logic                      n_div_done;
    logic signed [COORD_W-1:0] n_div_coord;
    logic signed [P_W-1:0]     n_prod;
    logic signed [ACC_W-1:0]   n_acc;

    cbs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (n_a),
        .i_b     (n_bop),
        .i_ctl   (n_ctl),
        .o_prod  (n_prod),
        .o_acc   (n_acc)
    );

    cbs_div3 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_value (n_acc[ACC_W-1:FRAC_W+1]),
        .o_done  (n_div_done),
        .o_coord (n_div_coord)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign n_in_take   = i_in_valid && (r_state == S_IDLE);
    assign n_out_load  = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign n_div_start = (r_state == S_DSTART);

    always_comb begin
        n_steps  = (r_step_count > STEP_W'(MAX_STEPS)) ? K_W'(MAX_STEPS)
                                                      : r_step_count[K_W-1:0];
        n_last   = (r_k == n_steps);
        n_t_sum  = {1'b0, r_t} + {1'b0, r_t_inc};
        n_t_next = (n_t_sum > (T_W+1)'(T_ONE)) ? T_ONE : n_t_sum[T_W-1:0];
        n_u      = T_ONE - r_t;
    end

    // weights as multiples of 2^-48, rounded half up to 2^-16
    always_comb begin
        n_s3  = BW_W'(1) << (3 * FRAC_W);
        n_te  = BW_W'(r_t);
        n_t2e = BW_W'(r_t2);
        n_t3e = BW_W'(r_t3);
        n_b[0] = BW_W'(n_prod[T3_W-1:0]);
        n_b[1] = (n_s3 << 2) + (n_t3e << 1) + n_t3e
               - (n_t2e << (FRAC_W + 1)) - (n_t2e << (FRAC_W + 2));
        n_b[2] = n_s3 + (n_te << (2 * FRAC_W + 1)) + (n_te << (2 * FRAC_W))
               + (n_t2e << (FRAC_W + 1)) + (n_t2e << FRAC_W)
               - (n_t3e << 1) - n_t3e;
        n_b[3] = n_t3e;
        for (int i = 0; i < 4; i++) begin
            n_rb[i] = n_b[i] + (BW_W'(1) << (2 * FRAC_W - 1));
        end
    end

    always_comb begin
        unique case (r_idx[2:1])
            2'd0:    n_coord = r_axis ? r_win_y[0] : r_win_x[0];
            2'd1:    n_coord = r_axis ? r_win_y[1] : r_win_x[1];
            2'd2:    n_coord = r_axis ? r_win_y[2] : r_win_x[2];
            default: n_coord = r_axis ? r_new_y : r_new_x;
        endcase
        n_coord_shr = n_coord >>> FRAC_W;
        n_hi        = n_coord_shr[HI_W-1:0];
        n_lo        = n_coord[FRAC_W-1:0];
    end

    always_comb begin
        n_a   = '0;
        n_bop = '0;
        n_ctl = '0;
        unique case (r_state)
            S_T2: begin
                n_a   = MA_W'(r_t);
                n_bop = MB_W'(r_t);
            end
            S_T3: begin
                n_a   = MA_W'(n_prod[T2_W-1:0]);
                n_bop = MB_W'(r_t);
            end
            S_U2: begin
                n_a   = MA_W'(n_u);
                n_bop = MB_W'(n_u);
            end
            S_U3: begin
                n_a   = MA_W'(n_prod[T2_W-1:0]);
                n_bop = MB_W'(n_u);
            end
            S_MUL: begin
                n_a          = MA_W'(r_w[r_idx[2:1]]);
                n_bop        = r_idx[0] ? MB_W'(n_lo) : MB_W'(n_hi);
                n_ctl.acc_en = 1'b1;
                n_ctl.first  = (r_idx == 3'd0);
                n_ctl.shift  = !r_idx[0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (n_in_take && (r_seen == 2'd3)) n_state = S_T2;
            S_T2:     n_state = S_T3;
            S_T3:     n_state = S_U2;
            S_U2:     n_state = S_U3;
            S_U3:     n_state = S_WGT;
            S_WGT:    n_state = S_MUL;
            S_MUL:    if (r_idx == 3'd7) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (n_div_done) n_state = r_axis ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (n_out_load) n_state = n_last ? S_IDLE : S_T2;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_count <= STEP_RESET;
            r_t_inc      <= INC_RESET;
            r_seen       <= 2'd0;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
            r_idx        <= '0;
            r_axis       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_win_x[i] <= '0;
                r_win_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_STEP_COUNT:  r_step_count <= i_cfg_data[STEP_W-1:0];
                    REG_T_INCREMENT: r_t_inc      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (n_in_take) begin
                r_k <= '0;
                if (r_seen != 2'd3) begin
                    r_seen     <= r_seen + 1'b1;
                    r_win_x[0] <= r_win_x[1];
                    r_win_x[1] <= r_win_x[2];
                    r_win_x[2] <= i_in_req.point_x;
                    r_win_y[0] <= r_win_y[1];
                    r_win_y[1] <= r_win_y[2];
                    r_win_y[2] <= i_in_req.point_y;
                end
            end
            if (r_state == S_WGT) begin
                r_idx  <= '0;
                r_axis <= 1'b0;
            end
            if (r_state == S_MUL) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((r_state == S_DWAIT) && n_div_done) begin
                r_idx  <= '0;
                r_axis <= 1'b1;
            end
            if (n_out_load) begin
                r_k <= r_k + 1'b1;
                if (n_last) begin
                    r_win_x[0] <= r_win_x[1];
                    r_win_x[1] <= r_win_x[2];
                    r_win_x[2] <= r_new_x;
                    r_win_y[0] <= r_win_y[1];
                    r_win_y[1] <= r_win_y[2];
                    r_win_y[2] <= r_new_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_take) begin
            r_new_x <= i_in_req.point_x;
            r_new_y <= i_in_req.point_y;
            r_t     <= '0;
        end
        if (r_state == S_T3) begin
            r_t2 <= n_prod[T2_W-1:0];
        end
        if (r_state == S_U2) begin
            r_t3 <= n_prod[T3_W-1:0];
        end
        if (r_state == S_WGT) begin
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= n_rb[i][2*FRAC_W+W_W-1:2*FRAC_W];
            end
        end
        if ((r_state == S_DWAIT) && n_div_done && !r_axis) begin
            r_res_x <= n_div_coord;
        end
        if (n_out_load) begin
            r_out_req.curve_x      <= r_res_x;
            r_out_req.curve_y      <= n_div_coord;
            r_out_req.segment_last <= n_last;
            r_t                    <= n_t_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

[design/cbs_mac.sv]
// ----------------------------------------------------------------------------
// cbs_mac
// Shared signed multiplier with a registered product and a delayed
// accumulator that sums weighted coordinate parts.
// ----------------------------------------------------------------------------
module cbs_mac
    import cbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [MA_W-1:0]  i_a,
    input  logic signed [MB_W-1:0]  i_b,
    input  t_mac_ctl                i_ctl,
    output logic signed [P_W-1:0]   o_prod,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_mac_ctl                r_ctl;
    logic signed [ACC_W-1:0] n_term;
    logic signed [ACC_W-1:0] n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_comb begin
        n_term = r_ctl.shift ? {r_prod[P_W-1], r_prod, {FRAC_W{1'b0}}} : ACC_W'(r_prod);
        n_base = r_ctl.first ? ROUND_BIAS : r_acc;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.acc_en) begin
            r_acc <= n_base + n_term;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

[design/cbs_div3.sv]
// ----------------------------------------------------------------------------
// cbs_div3
// Byte-serial floor division by three of a signed value, with saturation
// of the quotient to the coordinate range.
// ----------------------------------------------------------------------------
module cbs_div3
    import cbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [P_W-1:0]     i_value,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_coord
);

    localparam int CNT_W = $clog2(DIV_N + 1);
    localparam logic [DIV_W-1:0] U_BIAS = DIV_W'(3) << (P_W - 1);
    localparam logic signed [P_W-1:0] Q_MAX = P_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [P_W-1:0] Q_MIN = ~Q_MAX;

    logic [DIV_PAD-1:0] r_num;
    logic [DIV_PAD-1:0] r_quot;
    logic [1:0]         r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_W-1:0]      n_u;
    logic [1:0]            n_rem;
    logic [7:0]            n_byte;
    logic [2:0]            n_cur;
    logic signed [P_W-1:0] n_q;

    always_comb begin
        n_u    = {i_value[P_W-1], i_value} + U_BIAS;
        n_rem  = r_rem;
        n_byte = '0;
        n_cur  = '0;
        for (int j = 0; j < 8; j++) begin
            n_cur = {n_rem, r_num[DIV_PAD-1-j]};
            if (n_cur >= 3'd3) begin
                n_byte[7-j] = 1'b1;
                n_rem       = 2'(n_cur - 3'd3);
            end else begin
                n_byte[7-j] = 1'b0;
                n_rem       = n_cur[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIV_PAD'(n_u);
            r_rem <= 2'd0;
        end else if (r_busy) begin
            r_num  <= r_num << 8;
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIV_PAD-9:0], n_byte};
        end
    end

    always_comb begin
        n_q = {~r_quot[P_W-1], r_quot[P_W-2:0]};
        if (n_q > Q_MAX) begin
            o_coord = Q_MAX[COORD_W-1:0];
        end else if (n_q < Q_MIN) begin
            o_coord = Q_MIN[COORD_W-1:0];
        end else begin
            o_coord = n_q[COORD_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

[design/cbs_checker.sv]
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks of the cubic B-spline point generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module cbs_checker
    import cbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     o_in_stall,
    input  logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_out_req o_out_req
);

    // come out of reset empty and open for requests
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output pending or input stalled after reset");

    // a new request never yields a curve point in the very next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (!o_out_valid || !i_out_stall)) |=> !o_out_valid)
        else $error("curve point appeared right after request");

    // a segment is open until its last point has left
    a_segment_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_req.segment_last) |-> o_in_stall)
        else $error("input open while segment unfinished");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result changed");

endmodule

bind cubic_bspline_point_generator cbs_checker u_cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);
